FILE: rtl/dual_parallel_port_mailbox_assert.svh
// Assertion macros used by the mailbox checker.
`ifndef DUAL_PARALLEL_PORT_MAILBOX_ASSERT_SVH
`define DUAL_PARALLEL_PORT_MAILBOX_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mailbox check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is high.
`define DPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mailbox check failed: next-cycle rule");

`endif

FILE: rtl/dpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dpm_pkg;

   // Kind of access carried by one input word
   typedef enum logic [1:0] {
      MODE_READ  = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_POLL  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   // Register select, offset bits 2:1
   typedef enum logic [1:0] {
      REG_CSR  = 2'd0,
      REG_OBUF = 2'd1,
      REG_IBUF = 2'd2,
      REG_NONE = 2'd3
   } regsel_type;

   localparam int MEM_BLOCKS_W   = 3;
   localparam logic [MEM_BLOCKS_W-1:0] MEM_BLOCKS_RESET = 3'd4;

   // CSR bit positions
   localparam int CSR_IE_BIT     = 6;
   localparam int CSR_FLAG_BIT   = 7;

   // Status word: inactive-level bits
   localparam int ST_LVL0_BIT    = 7;
   localparam int ST_LVL1_BIT    = 15;
   localparam int ST_LVL2_BIT    = 6;
   localparam int ST_LVL3_BIT    = 14;

   // One accepted input word
   typedef struct packed {
      logic [1:0]  mode;
      logic        port_sel;
      logic [2:0]  reg_offset;
      logic [15:0] write_data;
      logic        word_access;
      logic [17:0] block_pointer;
      logic [3:0]  level_summary;
      logic        pointer_written;
      logic        summary_changed;
   } item_type;

   // One result word
   typedef struct packed {
      logic [15:0] read_data;
      logic        bus_error;
      logic        req_valid;
      logic [1:0]  req_level;
      logic [7:0]  req_vector;
      logic        pointer_ack;
      logic        clear_written;
      logic        clear_changed;
      logic        irq_first;
      logic        irq_second;
      logic        last;
   } rsp_type;

   // Free space in the result queue
   typedef struct packed {
      logic one;
      logic two;
   } room_type;

endpackage

`default_nettype wire

FILE: rtl/dpm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module dpm_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire dpm_pkg::item_type                    item,
   input  wire logic                                 fire,
   input  wire logic [dpm_pkg::MEM_BLOCKS_W-1:0]     mem_blocks,
   output dpm_pkg::rsp_type                          res0,
   output dpm_pkg::rsp_type                          res1,
   output logic                                      two
);
   import dpm_pkg::*;

   logic first_enable_ff, first_enable_in;
   logic first_done_ff, first_done_in;
   logic second_enable_ff, second_enable_in;
   logic second_newblock_ff, second_newblock_in;
   logic first_irq_ff, first_irq_in;
   logic second_irq_ff, second_irq_in;

   logic        done_chk;
   logic        odd;
   logic        ie;
   logic [1:0]  lvl_hi;
   logic [1:0]  lvl_lo;
   logic [15:0] status;

   assign odd    = item.reg_offset[0];
   assign ie     = item.write_data[CSR_IE_BIT];
   assign lvl_hi = {item.port_sel, 1'b1};
   assign lvl_lo = {item.port_sel, 1'b0};

   // Status word: pointer high bits, memory size, inactive levels
   always_comb begin
      status = '0;
      status[1:0]  = item.block_pointer[16:15];
      status[10:8] = mem_blocks;
      status[ST_LVL0_BIT] = ~item.level_summary[0];
      status[ST_LVL1_BIT] = ~item.level_summary[1];
      status[ST_LVL2_BIT] = ~item.level_summary[2];
      status[ST_LVL3_BIT] = ~item.level_summary[3];
   end

   // Decode the word, build results and next flag state
   always_comb begin
      first_enable_in    = first_enable_ff;
      first_done_in      = first_done_ff;
      second_enable_in   = second_enable_ff;
      second_newblock_in = second_newblock_ff;
      first_irq_in       = first_irq_ff;
      second_irq_in      = second_irq_ff;
      res0               = '0;
      res1               = '0;
      two                = 1'b0;
      done_chk           = 1'b0;

      case (mode_type'(item.mode))
         MODE_READ: begin
            case (regsel_type'(item.reg_offset[2:1]))
               REG_CSR: begin
                  if (!item.port_sel) begin
                     res0.read_data[CSR_IE_BIT]   = first_enable_ff;
                     res0.read_data[CSR_FLAG_BIT] = first_done_ff;
                  end else begin
                     res0.read_data[CSR_IE_BIT]   = second_enable_ff;
                     res0.read_data[CSR_FLAG_BIT] = second_newblock_ff;
                  end
               end
               REG_IBUF: begin
                  if (!item.port_sel) begin
                     res0.read_data = status;
                     done_chk       = 1'b1;
                  end else begin
                     res0.read_data     = {item.block_pointer[14:0], 1'b0};
                     second_newblock_in = 1'b0;
                     second_irq_in      = 1'b0;
                     res0.pointer_ack   = 1'b1;
                  end
               end
               REG_NONE: res0.bus_error = 1'b1;
               default: ;
            endcase
         end
         MODE_WRITE: begin
            case (regsel_type'(item.reg_offset[2:1]))
               REG_CSR: begin
                  if (!odd) begin
                     if (!item.port_sel) begin
                        if (!ie)
                           first_irq_in = 1'b0;
                        else if (first_done_ff && !first_enable_ff)
                           first_irq_in = 1'b1;
                        first_enable_in = ie;
                     end else begin
                        if (!ie)
                           second_irq_in = 1'b0;
                        else if (second_newblock_ff && !second_enable_ff)
                           second_irq_in = 1'b1;
                        second_enable_in = ie;
                     end
                  end
               end
               REG_OBUF: begin
                  res0.req_valid = 1'b1;
                  if (odd) begin
                     res0.req_level  = lvl_hi;
                     res0.req_vector = item.write_data[7:0];
                  end else if (item.word_access) begin
                     // High byte goes out first, low byte second
                     res0.req_level  = lvl_hi;
                     res0.req_vector = item.write_data[15:8];
                     res1.req_valid  = 1'b1;
                     res1.req_level  = lvl_lo;
                     res1.req_vector = item.write_data[7:0];
                     two             = 1'b1;
                  end else begin
                     res0.req_level  = lvl_lo;
                     res0.req_vector = item.write_data[7:0];
                  end
               end
               REG_NONE: res0.bus_error = 1'b1;
               default: ;
            endcase
         end
         MODE_POLL: begin
            if (item.pointer_written) begin
               second_newblock_in = 1'b1;
               if (second_enable_ff)
                  second_irq_in = 1'b1;
               res0.clear_written = 1'b1;
            end
            if (item.summary_changed) begin
               done_chk           = 1'b1;
               res0.clear_changed = 1'b1;
            end
         end
         default: ;
      endcase

      // Done check: partner went fully idle; flag is sticky until reset
      if (done_chk && item.level_summary == 4'd0 && !first_done_ff) begin
         first_done_in = 1'b1;
         if (first_enable_ff)
            first_irq_in = 1'b1;
      end

      res0.irq_first  = first_irq_in;
      res0.irq_second = second_irq_in;
      res0.last       = ~two;
      res1.irq_first  = first_irq_in;
      res1.irq_second = second_irq_in;
      res1.last       = 1'b1;
   end

   // Flag state
   always_ff @(posedge clock) begin
      if (reset) begin
         first_enable_ff    <= 1'b0;
         first_done_ff      <= 1'b0;
         second_enable_ff   <= 1'b0;
         second_newblock_ff <= 1'b0;
         first_irq_ff       <= 1'b0;
         second_irq_ff      <= 1'b0;
      end else if (fire) begin
         first_enable_ff    <= first_enable_in;
         first_done_ff      <= first_done_in;
         second_enable_ff   <= second_enable_in;
         second_newblock_ff <= second_newblock_in;
         first_irq_ff       <= first_irq_in;
         second_irq_ff      <= second_irq_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dpm_rsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module dpm_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic              push_two,
   input  wire dpm_pkg::rsp_type  wdata0,
   input  wire dpm_pkg::rsp_type  wdata1,
   output dpm_pkg::room_type      room,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output dpm_pkg::rsp_type       head
);
   import dpm_pkg::*;

   rsp_type    entry_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] push_n;

   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid & rsp_ready;
   assign head      = entry_ff[rd_ptr_ff];

   // Space left once this cycle's pop is counted
   assign room.one = (count_ff != 2'd2) | pop;
   assign room.two = (count_ff == 2'd0) | ((count_ff == 2'd1) & pop);

   assign push_n    = push ? (push_two ? 2'd2 : 2'd1) : 2'd0;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign wr_ptr_in = wr_ptr_ff ^ (push & ~push_two);
   assign count_in  = count_ff - {1'b0, pop} + push_n;

   // Pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage; a double push fills both slots in order
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata0;
         if (push_two)
            entry_ff[~wr_ptr_ff] <= wdata1;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/dual_parallel_port_mailbox.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                         Moves
// -------   ----------------------------  ---------------------------------
// request   req_valid / req_ready / req_* one bus read, bus write or poll word
// response  rsp_valid / rsp_ready / rsp_* one result word, last marks the end
// csr       csr_wr_en / csr_wr_data       local memory size, written at once
//
// One request word is taken per cycle while req_ready is high; its results
// are registered in the result queue. A full-word output-buffer write at an
// even offset gives two result words, so it holds the decode stage until the
// two-entry result queue has both slots free. Synchronous reset clears all
// flags, lines and queue state and loads a memory size of 4. A response stall
// backs up through the queue into the input register, then drops req_ready.

module dual_parallel_port_mailbox (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic        req_port_sel,
   input  wire logic [2:0]  req_reg_offset,
   input  wire logic [15:0] req_write_data,
   input  wire logic        req_word_access,
   input  wire logic [17:0] req_block_pointer,
   input  wire logic [3:0]  req_level_summary,
   input  wire logic        req_pointer_written,
   input  wire logic        req_summary_changed,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_read_data,
   output logic             rsp_bus_error,
   output logic             rsp_req_valid,
   output logic [1:0]       rsp_req_level,
   output logic [7:0]       rsp_req_vector,
   output logic             rsp_pointer_ack,
   output logic             rsp_clear_written,
   output logic             rsp_clear_changed,
   output logic             rsp_irq_first,
   output logic             rsp_irq_second,
   output logic             rsp_last,

   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_wr_data
);
   import dpm_pkg::*;

   item_type                 in_item_ff;
   logic                     in_valid_ff, in_valid_in;
   logic [MEM_BLOCKS_W-1:0]  mem_blocks_ff;
   logic                     fire;
   logic                     req_fire;
   logic                     two;
   rsp_type                  res0, res1, head;
   room_type                 room;

   // Input register handshake
   assign fire        = in_valid_ff & (two ? room.two : room.one);
   assign req_ready   = ~in_valid_ff | fire;
   assign req_fire    = req_valid & req_ready;
   assign in_valid_in = req_fire | (in_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset)
         in_valid_ff <= 1'b0;
      else
         in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.mode            <= req_mode;
         in_item_ff.port_sel        <= req_port_sel;
         in_item_ff.reg_offset      <= req_reg_offset;
         in_item_ff.write_data      <= req_write_data;
         in_item_ff.word_access     <= req_word_access;
         in_item_ff.block_pointer   <= req_block_pointer;
         in_item_ff.level_summary   <= req_level_summary;
         in_item_ff.pointer_written <= req_pointer_written;
         in_item_ff.summary_changed <= req_summary_changed;
      end
   end

   // Memory size register
   always_ff @(posedge clock) begin
      if (reset)
         mem_blocks_ff <= MEM_BLOCKS_RESET;
      else if (csr_wr_en)
         mem_blocks_ff <= csr_wr_data;
   end

   dpm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item       (in_item_ff),
      .fire       (fire),
      .mem_blocks (mem_blocks_ff),
      .res0       (res0),
      .res1       (res1),
      .two        (two)
   );

   dpm_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .push_two  (two),
      .wdata0    (res0),
      .wdata1    (res1),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_read_data     = head.read_data;
   assign rsp_bus_error     = head.bus_error;
   assign rsp_req_valid     = head.req_valid;
   assign rsp_req_level     = head.req_level;
   assign rsp_req_vector    = head.req_vector;
   assign rsp_pointer_ack   = head.pointer_ack;
   assign rsp_clear_written = head.clear_written;
   assign rsp_clear_changed = head.clear_changed;
   assign rsp_irq_first     = head.irq_first;
   assign rsp_irq_second    = head.irq_second;
   assign rsp_last          = head.last;

endmodule

`default_nettype wire

FILE: rtl/dpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "dual_parallel_port_mailbox_assert.svh"

module dpm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_read_data,
   input wire logic        rsp_bus_error,
   input wire logic        rsp_req_valid,
   input wire logic [1:0]  rsp_req_level,
   input wire logic [7:0]  rsp_req_vector,
   input wire logic        rsp_pointer_ack,
   input wire logic        rsp_irq_second,
   input wire logic        rsp_last
);

   // A stalled result word holds
   `DPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_req_vector) && $stable(rsp_last))

   // No request means zero level and vector
   `DPM_ASSERT_NOW(a_req_idle_zero, clock, reset, rsp_valid && !rsp_req_valid, rsp_req_level == 2'd0 && rsp_req_vector == 8'd0)

   // A bus error is a lone result with no data and no request
   `DPM_ASSERT_NOW(a_berr_alone, clock, reset, rsp_valid && rsp_bus_error, rsp_read_data == 16'd0 && !rsp_req_valid && rsp_last)

   // Only a request word can be followed by a second result
   `DPM_ASSERT_NOW(a_first_of_two, clock, reset, rsp_valid && !rsp_last, rsp_req_valid && rsp_req_level[0])

   // A pointer read drops the second line
   `DPM_ASSERT_NOW(a_ptr_ack_irq, clock, reset, rsp_valid && rsp_pointer_ack, !rsp_irq_second && rsp_last)

endmodule

bind dual_parallel_port_mailbox dpm_checker u_checker (.*);

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import dpm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SHOW_LIMIT  = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side, payload held in one packed word
   logic     req_valid = 1'b0;
   logic     req_ready;
   item_type req_word  = '0;

   // response side
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_read_data;
   logic        rsp_bus_error;
   logic        rsp_req_valid;
   logic [1:0]  rsp_req_level;
   logic [7:0]  rsp_req_vector;
   logic        rsp_pointer_ack;
   logic        rsp_clear_written;
   logic        rsp_clear_changed;
   logic        rsp_irq_first;
   logic        rsp_irq_second;
   logic        rsp_last;

   logic                    csr_wr_en   = 1'b0;
   logic [MEM_BLOCKS_W-1:0] csr_wr_data = '0;

   // words waiting to go in, result words still owed by the block
   item_type word_backlog[$];
   rsp_type  rsp_due[$];

   // local copy of the mailbox state
   logic [MEM_BLOCKS_W-1:0] mem_blocks = MEM_BLOCKS_RESET;
   logic first_en = 1'b0, first_done = 1'b0, first_irq = 1'b0;
   logic second_en = 1'b0, second_newblk = 1'b0, second_irq = 1'b0;

   // long receiver hold-off
   logic hold_start = 1'b0;
   logic hold_on    = 1'b0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;
   int fail_count = 0;
   int words_in = 0;
   int rsp_checked = 0;
   int vec_sent = 0;
   int ptr_reads = 0;
   int irq_rises = 0;

   dual_parallel_port_mailbox u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_word.mode),
      .req_port_sel        (req_word.port_sel),
      .req_reg_offset      (req_word.reg_offset),
      .req_write_data      (req_word.write_data),
      .req_word_access     (req_word.word_access),
      .req_block_pointer   (req_word.block_pointer),
      .req_level_summary   (req_word.level_summary),
      .req_pointer_written (req_word.pointer_written),
      .req_summary_changed (req_word.summary_changed),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_read_data       (rsp_read_data),
      .rsp_bus_error       (rsp_bus_error),
      .rsp_req_valid       (rsp_req_valid),
      .rsp_req_level       (rsp_req_level),
      .rsp_req_vector      (rsp_req_vector),
      .rsp_pointer_ack     (rsp_pointer_ack),
      .rsp_clear_written   (rsp_clear_written),
      .rsp_clear_changed   (rsp_clear_changed),
      .rsp_irq_first       (rsp_irq_first),
      .rsp_irq_second      (rsp_irq_second),
      .rsp_last            (rsp_last),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // done is latched the first time the partner's level summary reads all zero
   function automatic void check_done(input logic [3:0] summ);
      if (summ == 4'd0 && !first_done) begin
         first_done = 1'b1;
         if (first_en)
            first_irq = 1'b1;
      end
   endfunction

   // expected result words for one accepted word, state updated in place
   function automatic void mailbox_step(input item_type w);
      rsp_type    r0, r1;
      logic       odd;
      logic [1:0] lvl_base;
      int         n;
      r0 = '0;
      r1 = '0;
      n = 1;
      odd = w.reg_offset[0];
      lvl_base = w.port_sel ? 2'd2 : 2'd0;
      case (w.mode)
         MODE_READ: begin
            case (w.reg_offset[2:1])
               REG_NONE: r0.bus_error = 1'b1;
               REG_CSR: begin
                  r0.read_data[CSR_IE_BIT]   = w.port_sel ? second_en : first_en;
                  r0.read_data[CSR_FLAG_BIT] = w.port_sel ? second_newblk : first_done;
               end
               REG_IBUF: begin
                  if (!w.port_sel) begin
                     // status word: pointer high bits, memory size, idle levels
                     r0.read_data[1:0]         = w.block_pointer[16:15];
                     r0.read_data[10:8]        = mem_blocks;
                     r0.read_data[ST_LVL0_BIT] = ~w.level_summary[0];
                     r0.read_data[ST_LVL1_BIT] = ~w.level_summary[1];
                     r0.read_data[ST_LVL2_BIT] = ~w.level_summary[2];
                     r0.read_data[ST_LVL3_BIT] = ~w.level_summary[3];
                     check_done(w.level_summary);
                  end else begin
                     r0.read_data = {w.block_pointer[14:0], 1'b0};
                     r0.pointer_ack = 1'b1;
                     second_newblk = 1'b0;
                     second_irq = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         MODE_WRITE: begin
            case (w.reg_offset[2:1])
               REG_NONE: r0.bus_error = 1'b1;
               REG_CSR: begin
                  if (!odd && !w.port_sel) begin
                     if (!w.write_data[CSR_IE_BIT])
                        first_irq = 1'b0;
                     else if (first_done && !first_en)
                        first_irq = 1'b1;
                     first_en = w.write_data[CSR_IE_BIT];
                  end else if (!odd) begin
                     if (!w.write_data[CSR_IE_BIT])
                        second_irq = 1'b0;
                     else if (second_newblk && !second_en)
                        second_irq = 1'b1;
                     second_en = w.write_data[CSR_IE_BIT];
                  end
               end
               REG_OBUF: begin
                  r0.req_valid = 1'b1;
                  if (odd) begin
                     r0.req_level  = lvl_base + 2'd1;
                     r0.req_vector = w.write_data[7:0];
                  end else if (w.word_access) begin
                     // high byte goes out first, on the upper level
                     r0.req_level  = lvl_base + 2'd1;
                     r0.req_vector = w.write_data[15:8];
                     r1.req_valid  = 1'b1;
                     r1.req_level  = lvl_base;
                     r1.req_vector = w.write_data[7:0];
                     n = 2;
                  end else begin
                     r0.req_level  = lvl_base;
                     r0.req_vector = w.write_data[7:0];
                  end
               end
               default: ;
            endcase
         end
         MODE_POLL: begin
            if (w.pointer_written) begin
               second_newblk = 1'b1;
               if (second_en)
                  second_irq = 1'b1;
               r0.clear_written = 1'b1;
            end
            if (w.summary_changed) begin
               check_done(w.level_summary);
               r0.clear_changed = 1'b1;
            end
         end
         default: ;
      endcase
      r0.irq_first  = first_irq;
      r0.irq_second = second_irq;
      r1.irq_first  = first_irq;
      r1.irq_second = second_irq;
      if (n == 2) begin
         r1.last = 1'b1;
         rsp_due.push_back(r0);
         rsp_due.push_back(r1);
      end else begin
         r0.last = 1'b1;
         rsp_due.push_back(r0);
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= SHOW_LIMIT)
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endfunction

   function automatic item_type make_word(input logic [1:0] mode, input logic port,
                                          input logic [2:0] off, input logic [15:0] data,
                                          input logic whole, input logic [17:0] ptr,
                                          input logic [3:0] summ, input logic pw,
                                          input logic sc);
      item_type w;
      w.mode            = mode;
      w.port_sel        = port;
      w.reg_offset      = off;
      w.write_data      = data;
      w.word_access     = whole;
      w.block_pointer   = ptr;
      w.level_summary   = summ;
      w.pointer_written = pw;
      w.summary_changed = sc;
      return w;
   endfunction

   // random traffic, mostly register accesses and polls, level summary biased to zero
   function automatic item_type random_word();
      item_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < 36)
         w.mode = MODE_READ;
      else if (pick < 72)
         w.mode = MODE_WRITE;
      else if (pick < 93)
         w.mode = MODE_POLL;
      else
         w.mode = MODE_NONE;
      w.port_sel        = 1'($urandom_range(1));
      w.reg_offset      = 3'($urandom_range(7));
      w.write_data      = 16'($urandom_range(16'hffff));
      w.word_access     = 1'($urandom_range(1));
      w.block_pointer   = 18'($urandom_range(18'h3ffff));
      w.level_summary   = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(15));
      w.pointer_written = 1'($urandom_range(1));
      w.summary_changed = 1'($urandom_range(1));
      return w;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            mailbox_step(req_word);
            word_backlog.delete(0);
            words_in++;
         end
         if (word_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_word  <= word_backlog[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted in cycles on its own
   initial begin
      @(posedge hold_start);
      hold_on <= 1'b1;
      repeat (300) @(posedge clock);
      hold_on <= 1'b0;
   end

   // response monitor and ready control
   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_read_data, rsp_bus_error, rsp_req_valid, rsp_req_level,
                    rsp_req_vector, rsp_pointer_ack, rsp_clear_written,
                    rsp_clear_changed, rsp_irq_first, rsp_irq_second, rsp_last};
            if (rsp_due.size() == 0) begin
               fail_count++;
               if (fail_count <= SHOW_LIMIT)
                  $display("%0t ns: result word with nothing expected, got %h", $time, got);
            end else begin
               want = rsp_due.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("bus_error", 16'(want.bus_error), 16'(got.bus_error));
               check_field("req_valid", 16'(want.req_valid), 16'(got.req_valid));
               check_field("req_level", 16'(want.req_level), 16'(got.req_level));
               check_field("req_vector", 16'(want.req_vector), 16'(got.req_vector));
               check_field("pointer_ack", 16'(want.pointer_ack), 16'(got.pointer_ack));
               check_field("clear_written", 16'(want.clear_written),
                           16'(got.clear_written));
               check_field("clear_changed", 16'(want.clear_changed),
                           16'(got.clear_changed));
               check_field("irq_first", 16'(want.irq_first), 16'(got.irq_first));
               check_field("irq_second", 16'(want.irq_second), 16'(got.irq_second));
               check_field("last", 16'(want.last), 16'(got.last));
               if (want.req_valid)
                  vec_sent++;
               if (want.pointer_ack)
                  ptr_reads++;
               if (want.irq_first || want.irq_second)
                  irq_rises++;
            end
            rsp_checked++;
         end
         // hold off during the long stretch; otherwise stall at random
         if (hold_on)
            rsp_ready <= 1'b0;
         else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                  rsp_due.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // wait until every word is in and every result is out
   task automatic drain();
      while (word_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mem_blocks(input logic [MEM_BLOCKS_W-1:0] value);
      drain();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      mem_blocks = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int count, input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) word_backlog.push_back(random_word());
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words, memory size still at its reset value
      word_backlog.push_back(make_word(MODE_READ, 0, 3'd0, 0, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_READ, 1, 3'd1, 0, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_READ, 0, 3'd4, 0, 0, 18'h3ffff, 4'hf, 0, 0));
      word_backlog.push_back(make_word(MODE_READ, 1, 3'd4, 0, 0, 18'h3ffff, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_READ, 0, 3'd2, 0, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_READ, 0, 3'd7, 16'hffff, 1, 18'h3ffff, 0, 1, 1));
      word_backlog.push_back(make_word(MODE_WRITE, 1, 3'd6, 16'hffff, 1, 0, 0, 0, 0));
      // odd-byte CSR write is dropped
      word_backlog.push_back(make_word(MODE_WRITE, 0, 3'd1, 16'hffff, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_WRITE, 0, 3'd0, 16'h0040, 1, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_POLL, 0, 0, 0, 0, 0, 4'ha, 0, 1));
      word_backlog.push_back(make_word(MODE_WRITE, 0, 3'd4, 16'hffff, 1, 0, 0, 0, 0));
      // summary goes to zero with the line enabled: done and first line rise
      word_backlog.push_back(make_word(MODE_POLL, 1, 3'd7, 16'hffff, 1, 0, 0, 0, 1));
      word_backlog.push_back(make_word(MODE_READ, 0, 3'd0, 0, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_WRITE, 0, 3'd0, 16'hffbf, 1, 0, 0, 0, 0));
      // enable again while done is set raises the line
      word_backlog.push_back(make_word(MODE_WRITE, 0, 3'd0, 16'h0040, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_POLL, 0, 0, 0, 0, 0, 4'hf, 1, 0));
      word_backlog.push_back(make_word(MODE_WRITE, 1, 3'd0, 16'h0040, 1, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_READ, 1, 3'd0, 0, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_POLL, 0, 0, 0, 0, 0, 0, 1, 1));
      word_backlog.push_back(make_word(MODE_READ, 1, 3'd5, 0, 0, 18'h0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_READ, 0, 3'd5, 0, 0, 18'h18000, 0, 0, 0));
      // output buffer: full word, odd byte, even byte, full word at odd offset
      word_backlog.push_back(make_word(MODE_WRITE, 0, 3'd2, 16'ha55a, 1, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_WRITE, 1, 3'd3, 16'h12ff, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_WRITE, 1, 3'd2, 16'h0080, 0, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_WRITE, 1, 3'd3, 16'hffff, 1, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_WRITE, 1, 3'd2, 16'hffff, 1, 0, 0, 0, 0));
      word_backlog.push_back(make_word(MODE_NONE, 1, 3'd7, 16'hffff, 1, 18'h3ffff, 4'hf, 1, 1));
      drain();

      // back-pressure: responses held off while the sender keeps offering
      set_mem_blocks(3'd0);
      hold_start <= 1'b1;
      random_phase(400, 0, 0);

      set_mem_blocks(3'd7);
      random_phase(400, 74, 0);

      set_mem_blocks(3'($urandom_range(7)));
      random_phase(400, 0, 74);

      set_mem_blocks(3'($urandom_range(7)));
      random_phase(400, 14, 14);

      repeat (16) @(posedge clock);
      $display("covered %0d words in, %0d result words checked", words_in, rsp_checked);
      $display("%0d vector requests, %0d pointer reads, %0d results with a line up",
               vec_sent, ptr_reads, irq_rises);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/dpm_pkg.sv
rtl/dpm_core.sv
rtl/dpm_rsp_fifo.sv
rtl/dual_parallel_port_mailbox.sv
rtl/dpm_checker.sv
bench/tb_top.sv
